// ===== hdl/tcrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt compass package
// Widths, pipeline depths and the Q1.FRAC rounding helper that the top level,
// the unit-vector pipeline and the port checker share.
// ----------------------------------------------------------------------------
package tcrm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 14;
    localparam int OUT_W       = FRAC_BITS + 2;
    localparam int NUM_F       = 11;

    localparam int IN_TD_W  = ((6 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TD_W = ((NUM_F * OUT_W + 7) / 8) * 8;
    localparam int CFG_W    = 32;
    localparam int THR_W    = 2 * CFG_W;

    // Cross product and magnitudes.
    localparam int PROD_IN_W = 2 * SAMPLE_BITS;
    localparam int H_W       = PROD_IN_W + 1;
    localparam int MAG_W     = 2 * SAMPLE_BITS;
    localparam int SUMH_W    = 2 * MAG_W + 2;
    localparam int CMP_W     = (SUMH_W > THR_W) ? SUMH_W : THR_W;

    // Normalization: the largest magnitude lands in [2^29, 2^30).
    localparam int NORM_MSB  = 29;
    localparam int NORM_W    = NORM_MSB + 1;
    localparam int POS_W     = $clog2(MAG_W);
    localparam int SQR_W     = 2 * NORM_W;
    localparam int N2_W      = SQR_W + 2;
    localparam int SQ_W      = N2_W + 2;
    localparam int SQ_STEPS  = N2_W / 2;
    localparam int R_W       = SQ_STEPS;
    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int DIV_W     = NORM_W + FRAC_BITS + 2;

    // Register stages inside the unit-vector pipeline.
    localparam int UNIT_LAT  = 5 + SQ_STEPS + 1 + DIV_STEPS + 1;

    localparam int PROD_W = 2 * OUT_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int Q_W    = ACC_W + 1;

    // Field slots of one result beat, lowest first.
    localparam int F_EAST  = 0;
    localparam int F_NORTH = 3;
    localparam int F_UP    = 6;
    localparam int F_COS   = 9;
    localparam int F_SIN   = 10;

    // Round the magnitude half up by FRAC_BITS, clamp to one, restore the sign.
    function automatic logic signed [OUT_W-1:0] round_q(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] mag;
        logic [Q_W-1:0]   q;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        q = (Q_W'(mag) + Q_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (q > Q_W'(1 << FRAC_BITS)) begin
            q = Q_W'(1 << FRAC_BITS);
        end
        return v[ACC_W-1] ? OUT_W'(-q) : OUT_W'(q);
    endfunction

endpackage

// ===== hdl/tilt_compass_rotation_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt compass rotation matrix
// Gravity and geomagnetic samples in, east/north/up rows and inclination
// cosine and sine out, all in signed Q1.14.
// ----------------------------------------------------------------------------
// The block takes one sample pair per clock while s_axis tready is high and
// returns one result beat per sample pair, in order. The depth is set by the
// square root, which resolves one result bit per stage (31 stages), and the
// divider, which resolves one quotient bit per stage (15 stages); the rest is
// the cross products, normalization, sums of squares and rounding. A stalled
// output parks one beat in a skid register and then freezes the whole
// pipeline; s_axis tready is a register output. A new min_cross_norm is
// registered in r_min and squared into r_thr2 before the threshold test uses it.
module tilt_compass_rotation_matrix
    import tcrm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // grav_x, grav_y, grav_z, mag_x, mag_y, mag_z
    input  logic [IN_TD_W-1:0]  i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // east_x, east_y, east_z, north_x, north_y, north_z, up_x, up_y, up_z,
    // incl_cos, incl_sin
    output logic [OUT_TD_W-1:0] o_m_axis_tdata,
    // valid_res
    output logic                o_m_axis_tuser,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int DLY = UNIT_LAT - 2;

    logic                           en;

    logic [CFG_W-1:0]               r_min;
    logic [THR_W-1:0]               r_thr2;

    logic signed [SAMPLE_BITS-1:0]  w_a [3];
    logic signed [SAMPLE_BITS-1:0]  w_e [3];

    logic                           r_t1_vld;
    logic signed [SAMPLE_BITS-1:0]  r_t1_a [3];
    logic signed [SAMPLE_BITS-1:0]  r_t1_e [3];
    logic signed [PROD_IN_W-1:0]    r_t1_pr [6];

    logic                           r_t2_vld;
    logic signed [SAMPLE_BITS-1:0]  r_t2_a [3];
    logic signed [SAMPLE_BITS-1:0]  r_t2_e [3];
    logic signed [H_W-1:0]          r_t2_h [3];

    logic                           r_t3_vld;
    logic [2:0][MAG_W-1:0]          r_hmag;
    logic [2:0][MAG_W-1:0]          r_amag;
    logic [2:0][MAG_W-1:0]          r_emag;
    logic [2:0]                     r_hneg;
    logic [2:0]                     r_aneg;
    logic [2:0]                     r_eneg;

    logic                           r_t4_vld;
    logic [2*MAG_W-1:0]             r_t4_sq [3];
    logic                           r_t5_vld;
    logic [SUMH_W-1:0]              r_t5_sum;
    logic [DLY-1:0]                 r_dly_vld;
    logic [DLY-1:0]                 r_dly_ok;

    logic [2:0][OUT_W-1:0]          w_hu;
    logic [2:0][OUT_W-1:0]          w_au;
    logic [2:0][OUT_W-1:0]          w_eu;

    logic                           r_q1_vld;
    logic                           r_q1_ok;
    logic signed [OUT_W-1:0]        r_q1_hu [3];
    logic signed [OUT_W-1:0]        r_q1_au [3];
    logic signed [OUT_W-1:0]        r_q1_eu [3];
    logic signed [PROD_W-1:0]       r_q1_pr [6];

    logic                           r_q2_vld;
    logic                           r_q2_ok;
    logic signed [OUT_W-1:0]        r_q2_hu [3];
    logic signed [OUT_W-1:0]        r_q2_au [3];
    logic signed [OUT_W-1:0]        r_q2_eu [3];
    logic signed [OUT_W-1:0]        r_q2_mq [3];

    logic                           r_q3_vld;
    logic                           r_q3_ok;
    logic signed [OUT_W-1:0]        r_q3_hu [3];
    logic signed [OUT_W-1:0]        r_q3_au [3];
    logic signed [OUT_W-1:0]        r_q3_mq [3];
    logic signed [PROD_W-1:0]       r_q3_pc [3];
    logic signed [PROD_W-1:0]       r_q3_ps [3];

    logic                           r_res_vld;
    logic                           r_res_ok;
    logic [NUM_F-1:0][OUT_W-1:0]    r_res_f;
    logic [NUM_F-1:0][OUT_W-1:0]    n_res_f;

    logic                           r_skid_vld;
    logic                           r_skid_ok;
    logic [NUM_F-1:0][OUT_W-1:0]    r_skid_f;
    logic                           r_out_vld;
    logic                           r_out_ok;
    logic [NUM_F-1:0][OUT_W-1:0]    r_out_f;

    // The pipeline only moves while the skid register is free.
    assign en = !r_skid_vld;

    assign o_s_axis_tready = en;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= CFG_W'(1);
            r_thr2 <= THR_W'(1);
        end else begin
            if (i_cfg_valid) begin
                r_min <= i_cfg_data;
            end
            r_thr2 <= THR_W'(r_min) * THR_W'(r_min);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a[i] = $signed(i_s_axis_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]);
            w_e[i] = $signed(i_s_axis_tdata[(3+i)*SAMPLE_BITS +: SAMPLE_BITS]);
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_vld  <= 1'b0;
            r_t2_vld  <= 1'b0;
            r_t3_vld  <= 1'b0;
            r_t4_vld  <= 1'b0;
            r_t5_vld  <= 1'b0;
            r_dly_vld <= '0;
            r_q1_vld  <= 1'b0;
            r_q2_vld  <= 1'b0;
            r_q3_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else if (en) begin
            r_t1_vld  <= i_s_axis_tvalid;
            r_t2_vld  <= r_t1_vld;
            r_t3_vld  <= r_t2_vld;
            r_t4_vld  <= r_t3_vld;
            r_t5_vld  <= r_t4_vld;
            r_dly_vld <= {r_dly_vld[DLY-2:0], r_t5_vld};
            r_q1_vld  <= r_dly_vld[DLY-1];
            r_q2_vld  <= r_q1_vld;
            r_q3_vld  <= r_q2_vld;
            r_res_vld <= r_q3_vld;
        end
    end

    // Cross product H = E x A and the magnitudes for the three unit vectors.
    always_ff @(posedge i_clk) begin
        logic [H_W-1:0]         hm;
        logic [SAMPLE_BITS-1:0] am;
        logic [SAMPLE_BITS-1:0] em;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_t1_a[i] <= w_a[i];
                r_t1_e[i] <= w_e[i];
            end
            r_t1_pr[0] <= w_e[1] * w_a[2];
            r_t1_pr[1] <= w_e[2] * w_a[1];
            r_t1_pr[2] <= w_e[2] * w_a[0];
            r_t1_pr[3] <= w_e[0] * w_a[2];
            r_t1_pr[4] <= w_e[0] * w_a[1];
            r_t1_pr[5] <= w_e[1] * w_a[0];
            for (int i = 0; i < 3; i++) begin
                r_t2_a[i] <= r_t1_a[i];
                r_t2_e[i] <= r_t1_e[i];
                r_t2_h[i] <= H_W'(r_t1_pr[2*i]) - H_W'(r_t1_pr[2*i+1]);
            end
            for (int i = 0; i < 3; i++) begin
                hm = r_t2_h[i][H_W-1] ? H_W'(-r_t2_h[i]) : H_W'(r_t2_h[i]);
                am = r_t2_a[i][SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_t2_a[i])
                                              : SAMPLE_BITS'(r_t2_a[i]);
                em = r_t2_e[i][SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_t2_e[i])
                                              : SAMPLE_BITS'(r_t2_e[i]);
                r_hmag[i] <= hm[MAG_W-1:0];
                r_amag[i] <= MAG_W'(am);
                r_emag[i] <= MAG_W'(em);
                r_hneg[i] <= r_t2_h[i][H_W-1];
                r_aneg[i] <= r_t2_a[i][SAMPLE_BITS-1];
                r_eneg[i] <= r_t2_e[i][SAMPLE_BITS-1];
            end
        end
    end

    // Threshold test in exact integers, carried alongside the unit pipelines.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_t4_sq[i] <= (2*MAG_W)'(r_hmag[i]) * (2*MAG_W)'(r_hmag[i]);
            end
            r_t5_sum <= SUMH_W'(r_t4_sq[0]) + SUMH_W'(r_t4_sq[1]) + SUMH_W'(r_t4_sq[2]);
            r_dly_ok <= {r_dly_ok[DLY-2:0],
                         (r_t5_sum != '0) && (CMP_W'(r_t5_sum) >= CMP_W'(r_thr2))};
        end
    end

    tcrm_unit u_unit_h (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (r_hmag),
        .i_neg (r_hneg),
        .o_u   (w_hu)
    );

    tcrm_unit u_unit_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (r_amag),
        .i_neg (r_aneg),
        .o_u   (w_au)
    );

    tcrm_unit u_unit_e (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (r_emag),
        .i_neg (r_eneg),
        .o_u   (w_eu)
    );

    // North = up x east, then the inclination dot products.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q1_ok <= r_dly_ok[DLY-1];
            for (int i = 0; i < 3; i++) begin
                r_q1_hu[i] <= $signed(w_hu[i]);
                r_q1_au[i] <= $signed(w_au[i]);
                r_q1_eu[i] <= $signed(w_eu[i]);
            end
            r_q1_pr[0] <= $signed(w_au[1]) * $signed(w_hu[2]);
            r_q1_pr[1] <= $signed(w_au[2]) * $signed(w_hu[1]);
            r_q1_pr[2] <= $signed(w_au[2]) * $signed(w_hu[0]);
            r_q1_pr[3] <= $signed(w_au[0]) * $signed(w_hu[2]);
            r_q1_pr[4] <= $signed(w_au[0]) * $signed(w_hu[1]);
            r_q1_pr[5] <= $signed(w_au[1]) * $signed(w_hu[0]);

            r_q2_ok <= r_q1_ok;
            for (int i = 0; i < 3; i++) begin
                r_q2_hu[i] <= r_q1_hu[i];
                r_q2_au[i] <= r_q1_au[i];
                r_q2_eu[i] <= r_q1_eu[i];
                r_q2_mq[i] <= round_q(ACC_W'(r_q1_pr[2*i]) - ACC_W'(r_q1_pr[2*i+1]));
            end

            r_q3_ok <= r_q2_ok;
            for (int i = 0; i < 3; i++) begin
                r_q3_hu[i] <= r_q2_hu[i];
                r_q3_au[i] <= r_q2_au[i];
                r_q3_mq[i] <= r_q2_mq[i];
                r_q3_pc[i] <= r_q2_eu[i] * r_q2_mq[i];
                r_q3_ps[i] <= r_q2_eu[i] * r_q2_au[i];
            end

            r_res_ok <= r_q3_ok;
            r_res_f  <= n_res_f;
        end
    end

    // An invalid result clears every field.
    always_comb begin
        n_res_f = '0;
        if (r_q3_ok) begin
            for (int i = 0; i < 3; i++) begin
                n_res_f[F_EAST+i]  = r_q3_hu[i];
                n_res_f[F_NORTH+i] = r_q3_mq[i];
                n_res_f[F_UP+i]    = r_q3_au[i];
            end
            n_res_f[F_COS] = round_q(ACC_W'(r_q3_pc[0]) + ACC_W'(r_q3_pc[1])
                                   + ACC_W'(r_q3_pc[2]));
            n_res_f[F_SIN] = round_q(ACC_W'(r_q3_ps[0]) + ACC_W'(r_q3_ps[1])
                                   + ACC_W'(r_q3_ps[2]));
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_m_axis_tready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= r_res_vld;
            end
        end else if (en && r_res_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_m_axis_tready) begin
            if (r_skid_vld) begin
                r_out_ok <= r_skid_ok;
                r_out_f  <= r_skid_f;
            end else begin
                r_out_ok <= r_res_ok;
                r_out_f  <= r_res_f;
            end
        end else if (en && r_res_vld) begin
            r_skid_ok <= r_res_ok;
            r_skid_f  <= r_res_f;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out_ok;
    assign o_m_axis_tdata  = OUT_TD_W'(r_out_f);

endmodule

// ===== hdl/tcrm_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt compass unit-vector pipeline
// Scales three magnitudes, takes the integer square root of their sum of
// squares one bit per stage and divides each component by it, one quotient
// bit per stage. Every register advances only while i_en is high.
// ----------------------------------------------------------------------------
module tcrm_unit
    import tcrm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [2:0][MAG_W-1:0]  i_mag,
    input  logic [2:0]             i_neg,
    output logic [2:0][OUT_W-1:0]  o_u
);

    typedef struct packed {
        logic [SQ_W-1:0]           rem;
        logic [SQ_W-1:0]           res;
        logic [2:0][NORM_W-1:0]    m;
        logic [2:0]                neg;
    } t_sq;

    typedef struct packed {
        logic [2:0][DIV_W-1:0]     rem;
        logic [2:0][DIV_STEPS-1:0] q;
        logic [R_W-1:0]            r;
        logic [2:0]                neg;
    } t_dv;

    logic [2:0][MAG_W-1:0]  r_s1_m;
    logic [2:0]             r_s1_neg;
    logic [MAG_W-1:0]       r_s1_big;
    logic [MAG_W-1:0]       n_big;

    logic [2:0][MAG_W-1:0]  r_s2_m;
    logic [2:0]             r_s2_neg;
    logic [POS_W-1:0]       r_s2_pos;
    logic [POS_W-1:0]       n_pos;

    logic [2:0][NORM_W-1:0] r_s3_m;
    logic [2:0]             r_s3_neg;
    logic [2:0][NORM_W-1:0] n_norm;

    logic [2:0][NORM_W-1:0] r_s4_m;
    logic [2:0]             r_s4_neg;
    logic [2:0][SQR_W-1:0]  r_s4_sq;

    t_sq                    r_s5;
    t_sq                    w_sq [SQ_STEPS+1];
    t_dv                    r_dp;
    t_dv                    w_dv [DIV_STEPS+1];
    logic [2:0][OUT_W-1:0]  r_out;

    always_comb begin
        n_big = i_mag[0];
        if (i_mag[1] > n_big) begin
            n_big = i_mag[1];
        end
        if (i_mag[2] > n_big) begin
            n_big = i_mag[2];
        end
    end

    always_comb begin
        n_pos = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (r_s1_big[b]) begin
                n_pos = POS_W'(b);
            end
        end
    end

    // Right shifts drop low bits of every component, as a floor.
    always_comb begin
        logic [MAG_W+NORM_W-1:0] ext;
        for (int i = 0; i < 3; i++) begin
            ext = (MAG_W + NORM_W)'(r_s2_m[i]);
            if (int'(r_s2_pos) > NORM_MSB) begin
                ext = ext >> (int'(r_s2_pos) - NORM_MSB);
            end else begin
                ext = ext << (NORM_MSB - int'(r_s2_pos));
            end
            n_norm[i] = ext[NORM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_m   <= i_mag;
            r_s1_neg <= i_neg;
            r_s1_big <= n_big;
            r_s2_m   <= r_s1_m;
            r_s2_neg <= r_s1_neg;
            r_s2_pos <= n_pos;
            r_s3_m   <= n_norm;
            r_s3_neg <= r_s2_neg;
            r_s4_m   <= r_s3_m;
            r_s4_neg <= r_s3_neg;
            for (int i = 0; i < 3; i++) begin
                r_s4_sq[i] <= SQR_W'(r_s3_m[i]) * SQR_W'(r_s3_m[i]);
            end
            r_s5.rem <= SQ_W'(N2_W'(r_s4_sq[0]) + N2_W'(r_s4_sq[1]) + N2_W'(r_s4_sq[2]));
            r_s5.res <= '0;
            r_s5.m   <= r_s4_m;
            r_s5.neg <= r_s4_neg;
        end
    end

    assign w_sq[0] = r_s5;

    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - s));
        logic [SQ_W-1:0] w_trial;
        t_sq             r_q;

        assign w_trial = w_sq[s].res + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q.m   <= w_sq[s].m;
                r_q.neg <= w_sq[s].neg;
                if (w_sq[s].rem >= w_trial) begin
                    r_q.rem <= w_sq[s].rem - w_trial;
                    r_q.res <= (w_sq[s].res >> 1) + BIT;
                end else begin
                    r_q.rem <= w_sq[s].rem;
                    r_q.res <= w_sq[s].res >> 1;
                end
            end
        end

        assign w_sq[s+1] = r_q;
    end

    // Dividend carries the half-divisor so the quotient rounds half up.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_dp.rem[i] <= (DIV_W'(w_sq[SQ_STEPS].m[i]) << FRAC_BITS)
                             + DIV_W'(w_sq[SQ_STEPS].res >> 1);
            end
            r_dp.q   <= '0;
            r_dp.r   <= w_sq[SQ_STEPS].res[R_W-1:0];
            r_dp.neg <= w_sq[SQ_STEPS].neg;
        end
    end

    assign w_dv[0] = r_dp;

    for (genvar d = 0; d < DIV_STEPS; d++) begin : g_div
        localparam int K = DIV_STEPS - 1 - d;
        logic [DIV_W-1:0] w_sub;
        t_dv              r_q;

        assign w_sub = DIV_W'(w_dv[d].r) << K;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q.r   <= w_dv[d].r;
                r_q.neg <= w_dv[d].neg;
                for (int i = 0; i < 3; i++) begin
                    if (w_dv[d].rem[i] >= w_sub) begin
                        r_q.rem[i] <= w_dv[d].rem[i] - w_sub;
                        r_q.q[i]   <= w_dv[d].q[i] | (DIV_STEPS'(1) << K);
                    end else begin
                        r_q.rem[i] <= w_dv[d].rem[i];
                        r_q.q[i]   <= w_dv[d].q[i];
                    end
                end
            end
        end

        assign w_dv[d+1] = r_q;
    end

    always_ff @(posedge i_clk) begin
        logic [DIV_STEPS-1:0] q;
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                q = w_dv[DIV_STEPS].q[i];
                if (q > DIV_STEPS'(1 << FRAC_BITS)) begin
                    q = DIV_STEPS'(1 << FRAC_BITS);
                end
                r_out[i] <= w_dv[DIV_STEPS].neg[i] ? OUT_W'(-OUT_W'(q)) : OUT_W'(q);
            end
        end
    end

    assign o_u = r_out;

endmodule

// ===== hdl/tcrm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt compass port checker
// Watches the top-level ports for reset, stall and result rules.
// ----------------------------------------------------------------------------
module tcrm_checker
    import tcrm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_s_axis_tready,
    input  logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    input  logic [OUT_TD_W-1:0] o_m_axis_tdata,
    input  logic                o_m_axis_tuser
);

    logic signed [OUT_W-1:0] east_x;
    logic signed [OUT_W-1:0] incl_sin;

    assign east_x   = $signed(o_m_axis_tdata[F_EAST*OUT_W +: OUT_W]);
    assign incl_sin = $signed(o_m_axis_tdata[F_SIN*OUT_W +: OUT_W]);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output beat valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled output beat changed");

    // Input backpressure only ever comes from a waiting output beat.
    a_ready_low_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with no output beat pending");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("invalid result carries nonzero fields");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            (east_x <= OUT_W'(1 << FRAC_BITS)) && (east_x >= -OUT_W'(1 << FRAC_BITS))
            && (incl_sin <= OUT_W'(1 << FRAC_BITS)) && (incl_sin >= -OUT_W'(1 << FRAC_BITS)))
        else $error("result field beyond unit range");

endmodule

bind tilt_compass_rotation_matrix tcrm_checker u_tcrm_checker (.*);
